@@ design/whs_pkg.sv @@
// Shared types and constants for the WebP header sniffer.
// Holds the chunk tags, result codes and the result record; no dependencies.
`default_nettype none

package whs_pkg;

  // Four-character tags as they appear in file order, first byte in the MSBs.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WEBP = 32'h5745_4250;
  localparam logic [31:0] TAG_VP8  = 32'h5650_3820;
  localparam logic [31:0] TAG_VP8L = 32'h5650_384C;
  localparam logic [31:0] TAG_VP8X = 32'h5650_3858;

  // VP8 start code and VP8L signature byte.
  localparam logic [7:0] VP8_SYNC0     = 8'h9D;
  localparam logic [7:0] VP8_SYNC1     = 8'h01;
  localparam logic [7:0] VP8_SYNC2     = 8'h2A;
  localparam logic [7:0] VP8L_SIGNATURE = 8'h2F;

  // Smallest RIFF sizes that can hold a usable header.
  localparam logic [31:0] MIN_SIZE_ANY = 32'd25;
  localparam logic [31:0] MIN_SIZE_VP8 = 32'd26;

  typedef enum logic [1:0] {
    VERDICT_UNUSABLE = 2'd0,
    VERDICT_LOSSY    = 2'd1,
    VERDICT_LOSSLESS = 2'd2,
    VERDICT_EXTENDED = 2'd3
  } verdict_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_MAGIC     = 4'd1,
    ERR_SIZE      = 4'd2,
    ERR_TAG       = 4'd3,
    ERR_SYNC      = 4'd4,
    ERR_SIGNATURE = 4'd5,
    ERR_VERSION   = 4'd6,
    ERR_ANIMATED  = 4'd7,
    ERR_TRUNCATED = 4'd8
  } err_t;

  // One input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       last;
  } item_t;

  // One result record.
  typedef struct packed {
    verdict_t    verdict;
    err_t        error_code;
    logic [24:0] width;
    logic [24:0] height;
    logic        alpha_flag;
    logic        animated;
  } result_t;

endpackage

`default_nettype wire

@@ design/whs_if.sv @@
// Valid/ready channel interfaces for the WebP header sniffer.
// Depends on nothing; the byte channel feeds the parser, the result channel leaves it.
`default_nettype none

interface whs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;
  logic       last;

  modport source (output valid, output data_byte, output start_req, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input start_req, input last,
                  output ready);
endinterface

interface whs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [3:0]  error_code;
  logic [24:0] width;
  logic [24:0] height;
  logic        alpha_flag;
  logic        animated;

  modport source (output valid, output verdict, output error_code, output width,
                  output height, output alpha_flag, output animated, input ready);
  modport sink   (input valid, input verdict, input error_code, input width,
                  input height, input alpha_flag, input animated, output ready);
endinterface

`default_nettype wire

@@ design/whs_parser.sv @@
// Header parse state and per-byte decision logic of the WebP header sniffer.
// Uses whs_pkg for tags, codes and the request and result records.
`default_nettype none

module whs_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            take,
  input  whs_pkg::item_t       item,
  output logic                 hit,
  output whs_pkg::result_t     res
);

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_VP8  = 2'd1,
    KIND_VP8L = 2'd2,
    KIND_VP8X = 2'd3
  } kind_t;

  logic [4:0]  pos_r, pos_nxt, pos_e;
  kind_t       kind_r, kind_nxt, kind_e;
  logic [31:0] aw_r, aw_nxt, aw_e;
  logic [31:0] riff_r, riff_nxt, riff_e;
  logic [23:0] w_r, w_nxt, w_e;
  logic [23:0] h_r, h_nxt, h_e;
  logic [1:0]  flags_r, flags_nxt, flags_e;
  logic        decided_r, decided_nxt, decided_e;

  logic        restart;
  logic        done;
  logic [7:0]  b;
  logic [31:0] vp8l_word;

  function automatic whs_pkg::result_t make_result(
    input whs_pkg::verdict_t v,
    input whs_pkg::err_t     e,
    input logic [24:0]       w,
    input logic [24:0]       h,
    input logic              a,
    input logic              an
  );
    whs_pkg::result_t r;
    r.verdict    = v;
    r.error_code = e;
    r.width      = w;
    r.height     = h;
    r.alpha_flag = a;
    r.animated   = an;
    return r;
  endfunction

  // A start request clears the parse before the byte is looked at.
  assign restart   = take & item.start_req;
  assign b         = item.data_byte;
  assign pos_e     = restart ? 5'd0 : pos_r;
  assign kind_e    = restart ? KIND_NONE : kind_r;
  assign aw_e      = restart ? 32'd0 : aw_r;
  assign riff_e    = restart ? 32'd0 : riff_r;
  assign w_e       = restart ? 24'd0 : w_r;
  assign h_e       = restart ? 24'd0 : h_r;
  assign flags_e   = restart ? 2'd0 : flags_r;
  assign decided_e = restart ? 1'b0 : decided_r;

  // The VP8L header word, completed by the byte at position 24.
  assign vp8l_word = {b, aw_e[23:0]};

  // Per-byte decision: update the fields and decide the file where possible.
  always_comb begin
    pos_nxt     = pos_r;
    kind_nxt    = kind_r;
    aw_nxt      = aw_r;
    riff_nxt    = riff_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    flags_nxt   = flags_r;
    decided_nxt = decided_r;
    hit         = 1'b0;
    done        = 1'b0;
    res         = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_NONE,
                              25'd0, 25'd0, 1'b0, 1'b0);
    if (take) begin
      pos_nxt     = pos_e;
      kind_nxt    = kind_e;
      aw_nxt      = aw_e;
      riff_nxt    = riff_e;
      w_nxt       = w_e;
      h_nxt       = h_e;
      flags_nxt   = flags_e;
      decided_nxt = decided_e;
      if (!decided_e) begin
        if (pos_e < 5'd4) begin
          // RIFF magic.
          aw_nxt = {aw_e[23:0], b};
          if (pos_e == 5'd3 && aw_nxt != whs_pkg::TAG_RIFF) begin
            res  = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_MAGIC,
                               25'd0, 25'd0, 1'b0, 1'b0);
            done = 1'b1;
          end
        end else if (pos_e < 5'd8) begin
          // Little-endian RIFF size.
          riff_nxt[{pos_e[1:0], 3'b000} +: 8] = b;
          if (pos_e == 5'd7 && riff_nxt < whs_pkg::MIN_SIZE_ANY) begin
            res  = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_SIZE,
                               25'd0, 25'd0, 1'b0, 1'b0);
            done = 1'b1;
          end
        end else if (pos_e < 5'd12) begin
          // WEBP form tag.
          aw_nxt = {aw_e[23:0], b};
          if (pos_e == 5'd11 && aw_nxt != whs_pkg::TAG_WEBP) begin
            res  = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_TAG,
                               25'd0, 25'd0, 1'b0, 1'b0);
            done = 1'b1;
          end
        end else if (pos_e < 5'd16) begin
          // First chunk tag selects the header layout.
          aw_nxt = {aw_e[23:0], b};
          if (pos_e == 5'd15) begin
            if (aw_nxt == whs_pkg::TAG_VP8 || aw_nxt == whs_pkg::TAG_VP8X) begin
              if (riff_e < whs_pkg::MIN_SIZE_VP8) begin
                res  = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_SIZE,
                                   25'd0, 25'd0, 1'b0, 1'b0);
                done = 1'b1;
              end else begin
                kind_nxt = (aw_nxt == whs_pkg::TAG_VP8) ? KIND_VP8 : KIND_VP8X;
              end
            end else if (aw_nxt == whs_pkg::TAG_VP8L) begin
              kind_nxt = KIND_VP8L;
            end else begin
              res  = make_result(whs_pkg::VERDICT_LOSSY, whs_pkg::ERR_NONE,
                                 25'd0, 25'd0, 1'b0, 1'b0);
              done = 1'b1;
            end
          end
        end else if (pos_e >= 5'd20) begin
          case (kind_e)
            KIND_VP8: begin
              // Start code, then 14-bit width and height; scale bits dropped.
              if ((pos_e == 5'd23 && b != whs_pkg::VP8_SYNC0) ||
                  (pos_e == 5'd24 && b != whs_pkg::VP8_SYNC1) ||
                  (pos_e == 5'd25 && b != whs_pkg::VP8_SYNC2)) begin
                res  = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_SYNC,
                                   25'd0, 25'd0, 1'b0, 1'b0);
                done = 1'b1;
              end else begin
                if (pos_e == 5'd26) w_nxt = {16'd0, b};
                if (pos_e == 5'd27) w_nxt = {10'd0, b[5:0], w_e[7:0]};
                if (pos_e == 5'd28) h_nxt = {16'd0, b};
                if (pos_e == 5'd29) begin
                  h_nxt = {10'd0, b[5:0], h_e[7:0]};
                  res   = make_result(whs_pkg::VERDICT_LOSSY, whs_pkg::ERR_NONE,
                                      {11'd0, w_e[13:0]}, {11'd0, b[5:0], h_e[7:0]},
                                      1'b0, 1'b0);
                  done  = 1'b1;
                end
              end
            end
            KIND_VP8L: begin
              // Signature, then one little-endian 32-bit header word.
              if (pos_e == 5'd20 && b != whs_pkg::VP8L_SIGNATURE) begin
                res  = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_SIGNATURE,
                                   25'd0, 25'd0, 1'b0, 1'b0);
                done = 1'b1;
              end
              if (pos_e == 5'd21) aw_nxt = {24'd0, b};
              if (pos_e == 5'd22) aw_nxt[15:8]  = b;
              if (pos_e == 5'd23) aw_nxt[23:16] = b;
              if (pos_e == 5'd24) begin
                aw_nxt = vp8l_word;
                if (vp8l_word[31:29] != 3'd0) begin
                  res = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_VERSION,
                                    25'd0, 25'd0, 1'b0, 1'b0);
                end else begin
                  res = make_result(whs_pkg::VERDICT_LOSSLESS, whs_pkg::ERR_NONE,
                                    {11'd0, vp8l_word[13:0]} + 25'd1,
                                    {11'd0, vp8l_word[27:14]} + 25'd1,
                                    vp8l_word[28], 1'b0);
                end
                done = 1'b1;
              end
            end
            KIND_VP8X: begin
              // Flags byte, then 24-bit canvas width and height minus one.
              if (pos_e == 5'd20) flags_nxt = {b[1], b[4]};
              if (pos_e == 5'd24) w_nxt[7:0]   = b;
              if (pos_e == 5'd25) w_nxt[15:8]  = b;
              if (pos_e == 5'd26) w_nxt[23:16] = b;
              if (pos_e == 5'd27) h_nxt[7:0]   = b;
              if (pos_e == 5'd28) h_nxt[15:8]  = b;
              if (pos_e == 5'd29) begin
                h_nxt[23:16] = b;
                if (flags_e[1]) begin
                  res = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_ANIMATED,
                                    {1'b0, w_e} + 25'd1, {1'b0, b, h_e[15:0]} + 25'd1,
                                    flags_e[0], 1'b1);
                end else begin
                  res = make_result(whs_pkg::VERDICT_EXTENDED, whs_pkg::ERR_NONE,
                                    {1'b0, w_e} + 25'd1, {1'b0, b, h_e[15:0]} + 25'd1,
                                    flags_e[0], 1'b0);
                end
                done = 1'b1;
              end
            end
            default: ;
          endcase
        end

        // A byte that decides nothing moves on; if it is the last, the file is short.
        if (done) begin
          hit         = 1'b1;
          decided_nxt = 1'b1;
        end else begin
          pos_nxt = pos_e + 5'd1;
          if (item.last) begin
            hit         = 1'b1;
            decided_nxt = 1'b1;
            res         = make_result(whs_pkg::VERDICT_UNUSABLE, whs_pkg::ERR_TRUNCATED,
                                      25'd0, 25'd0, 1'b0, 1'b0);
          end
        end
      end
    end
  end

  // Parse state registers; after reset the parser waits for a start request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 5'd0;
      kind_r    <= KIND_NONE;
      aw_r      <= 32'd0;
      riff_r    <= 32'd0;
      w_r       <= 24'd0;
      h_r       <= 24'd0;
      flags_r   <= 2'd0;
      decided_r <= 1'b1;
    end else begin
      pos_r     <= pos_nxt;
      kind_r    <= kind_nxt;
      aw_r      <= aw_nxt;
      riff_r    <= riff_nxt;
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      flags_r   <= flags_nxt;
      decided_r <= decided_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/webp_header_sniffer.sv @@
// WebP header sniffer: one byte per cycle, one result per file.
// The result is registered and is valid in the cycle after the request that decides the file.
// Throughput: one byte a cycle; bytes are held off only while a result waits unaccepted.
// Reset: parse state cleared, output empty, bytes ignored until a start request.
// Depends on whs_pkg, whs_in_if, whs_out_if and whs_parser.
`default_nettype none

module webp_header_sniffer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  whs_in_if.sink     in_ch,
  whs_out_if.source  out_ch
);

  whs_pkg::item_t   item;
  whs_pkg::result_t res;
  whs_pkg::result_t out_data_r;
  logic             out_valid_r;
  logic             take;
  logic             hit;

  // A byte is taken whenever the result register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  assign item.data_byte = in_ch.data_byte;
  assign item.start_req = in_ch.start_req;
  assign item.last      = in_ch.last;

  whs_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .hit   (hit),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hit) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.verdict    = out_data_r.verdict;
  assign out_ch.error_code = out_data_r.error_code;
  assign out_ch.width      = out_data_r.width;
  assign out_ch.height     = out_data_r.height;
  assign out_ch.alpha_flag = out_data_r.alpha_flag;
  assign out_ch.animated   = out_data_r.animated;

endmodule

`default_nettype wire
